[rtl/core/srag_pkg.sv]
// Shared types and constants for the smallest covering range block.
// Used by the cell chain, the tail stage and the top level; no dependencies.
package srag_pkg;

  localparam int VALUE_W         = 32;
  localparam int GROUP_W         = 9;
  localparam int CNT_W           = 10;
  localparam int SPAN_W          = VALUE_W + 1;
  localparam int MAX_GROUPS_DEF  = 512;
  localparam int GROUP_COUNT_RST = 1;

  // register indexes on the configuration port
  localparam int REG_GROUP_COUNT = 0;

  // word that walks down the chain, one cell per cycle while the chain advances
  typedef struct packed {
    logic                      valid;
    logic                      last;
    logic                      live;   // group lies inside the store
    logic [GROUP_W-1:0]        group;
    logic signed [VALUE_W-1:0] value;
    logic                      cov;    // every needed group seen so far
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
  } cell_word_t;

endpackage

[rtl/core/smallest_range_all_groups.sv]
// Top level of the smallest covering range block: config register, cell chain, tail.
// Depends on srag_pkg, srag_cell and srag_tail.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   in       | in_valid / in_stall  | in_value, in_group, in_last_item
//   out      | out_valid / out_stall| out_range_low, out_range_high, out_found
//   cfg      | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// A word enters the chain every cycle and visits one cell per cycle, so a new
// item is taken each cycle unless in_stall holds the chain; out_valid rises
// once the last item of a set has passed every cell and reached the tail.
// Reset clears the seen marks in every cell at once, no clearing pass.
// While a result waits under out_stall the whole chain holds and in_stall is high.
module smallest_range_all_groups import srag_pkg::*; #(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [GROUP_W-1:0]        in_group,
  input  logic                      in_last_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_range_low,
  output logic signed [VALUE_W-1:0] out_range_high,
  output logic                      out_found,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic             adv;
  logic             reg_hit;
  logic [CNT_W-1:0] group_count_r;
  logic [CNT_W-1:0] cnt;
  cell_word_t       chain [MAX_GROUPS+1];

  assign pready  = 1'b1;
  assign reg_hit = ({29'b0, paddr[2]} == 32'(REG_GROUP_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r <= CNT_W'(GROUP_COUNT_RST);
    end else if (psel && penable && pwrite && reg_hit) begin
      group_count_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? {{(32-CNT_W){1'b0}}, group_count_r} : 32'b0;

  // clamp the group count to 1 .. MAX_GROUPS
  always_comb begin
    if (group_count_r == '0) cnt = CNT_W'(1);
    else if ({{(32-CNT_W){1'b0}}, group_count_r} > MAX_GROUPS) cnt = CNT_W'(MAX_GROUPS);
    else cnt = group_count_r;
  end

  // hold everything while a result waits
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].last  = in_last_item;
    chain[0].live  = {{(32-GROUP_W){1'b0}}, in_group} < MAX_GROUPS;
    chain[0].group = in_group;
    chain[0].value = in_value;
    chain[0].cov   = 1'b1;
    chain[0].lo    = '0;
    chain[0].hi    = '0;
  end

  for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
    srag_cell #(
      .INDEX(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cnt   (cnt),
      .word_i(chain[i]),
      .word_o(chain[i+1])
    );
  end

  srag_tail u_tail (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .word_i        (chain[MAX_GROUPS]),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_range_low (out_range_low),
    .out_range_high(out_range_high),
    .out_found     (out_found)
  );

endmodule

[rtl/core/srag_cell.sv]
// One cell of the group chain: holds the latest value and seen mark of one group.
// Folds its value into the passing word's coverage and min/max. Depends on srag_pkg.
module srag_cell import srag_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [CNT_W-1:0] cnt,
  input  cell_word_t       word_i,
  output cell_word_t       word_o
);

  logic                      hit;
  logic                      need;
  logic                      seen_now;
  logic signed [VALUE_W-1:0] x;

  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      seen_r, seen_nxt;
  logic                      valid_r;
  cell_word_t                data_r, data_nxt;

  assign hit  = word_i.valid &&
                ({{(32-GROUP_W){1'b0}}, word_i.group} == 32'(INDEX));
  assign need = 32'(INDEX) < {{(32-CNT_W){1'b0}}, cnt};

  always_comb begin
    x         = hit ? word_i.value : value_r;
    seen_now  = hit | seen_r;
    data_nxt  = word_i;
    if (need) begin
      data_nxt.cov = word_i.cov & seen_now;
      if (INDEX == 0) begin
        data_nxt.lo = x;
        data_nxt.hi = x;
      end else begin
        if (x < word_i.lo) data_nxt.lo = x;
        if (x > word_i.hi) data_nxt.hi = x;
      end
    end
    value_nxt = x;
    seen_nxt  = seen_now;
    // drop the mark once the closing word has passed
    if (word_i.valid && word_i.last) seen_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      valid_r <= 1'b0;
    end else if (adv) begin
      seen_r  <= seen_nxt;
      valid_r <= word_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
      data_r  <= data_nxt;
    end
  end

  always_comb begin
    word_o       = data_r;
    word_o.valid = valid_r;
  end

endmodule

[rtl/core/srag_tail.sv]
// Tail of the chain: keeps the best span found and loads the result register.
// Takes words from the last cell. Depends on srag_pkg.
module srag_tail import srag_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  cell_word_t                word_i,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_range_low,
  output logic signed [VALUE_W-1:0] out_range_high,
  output logic                      out_found
);

  logic [SPAN_W-1:0]         span;
  logic                      take;
  logic                      closing;
  logic                      cur_valid;
  logic signed [VALUE_W-1:0] cur_low, cur_high;

  logic                      best_valid_r, best_valid_nxt;
  logic [SPAN_W-1:0]         best_span_r, best_span_nxt;
  logic signed [VALUE_W-1:0] best_low_r, best_low_nxt;
  logic signed [VALUE_W-1:0] best_high_r, best_high_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_low_r, out_high_r;
  logic                      out_found_r;

  assign span = {word_i.hi[VALUE_W-1], word_i.hi} - {word_i.lo[VALUE_W-1], word_i.lo};
  assign take = word_i.valid && word_i.live && word_i.cov &&
                (!best_valid_r || (span < best_span_r));
  assign closing = word_i.valid && word_i.last;

  always_comb begin
    cur_valid = best_valid_r | take;
    cur_low   = take ? word_i.lo : best_low_r;
    cur_high  = take ? word_i.hi : best_high_r;

    best_valid_nxt = cur_valid;
    best_span_nxt  = take ? span : best_span_r;
    best_low_nxt   = cur_low;
    best_high_nxt  = cur_high;
    if (closing) begin
      best_valid_nxt = 1'b0;
      best_span_nxt  = '0;
      best_low_nxt   = '0;
      best_high_nxt  = '0;
    end

    if (adv && closing) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      best_span_r  <= '0;
      best_low_r   <= '0;
      best_high_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        best_valid_r <= best_valid_nxt;
        best_span_r  <= best_span_nxt;
        best_low_r   <= best_low_nxt;
        best_high_r  <= best_high_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && closing) begin
      out_low_r   <= cur_valid ? cur_low  : '0;
      out_high_r  <= cur_valid ? cur_high : '0;
      out_found_r <= cur_valid;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_range_low  = out_low_r;
  assign out_range_high = out_high_r;
  assign out_found      = out_found_r;

endmodule
